>>> sv/assert_macros.svh
// Assertion macros shared by the call auction modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/cau_pkg.sv
// Types, constants and codes of the call auction uncrossing block.
package cau_pkg;

  localparam int BOOK_DEPTH  = 32;
  localparam int IDX_W       = $clog2(BOOK_DEPTH);
  localparam int VOL_W       = 32 + $clog2(BOOK_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BOOK_DEPTH - 1);

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_UNCROSS = 2'd2;

  localparam logic [1:0] KIND_ADD_ACK = 2'd0;
  localparam logic [1:0] KIND_RM_ACK  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_FILL    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_REF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEN = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        order_tag;
    logic               order_is_buy;
    logic signed [31:0] order_price;
    logic [31:0]        order_quantity;
    logic [47:0]        order_time;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               ok;
    logic [15:0]        fill_tag;
    logic               fill_is_buy;
    logic [36:0]        amount;
    logic signed [31:0] cross_price;
    logic               beyond_band;
    logic               last;
  } res_t;

  // Handshake between front queue and back sequencer.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_RM_SCAN, S_RM_ACK, S_UX_CAND, S_UX_SUM, S_UX_EVAL,
    S_UX_DONE, S_BAND, S_SUMMARY, S_FILL_SCAN, S_FILL_DEC, S_FILL_EMIT
  } state_t;

endpackage

>>> sv/cau_item_if.sv
// Input item channel.
interface cau_item_if;
  import cau_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        order_tag;
  logic               order_is_buy;
  logic signed [31:0] order_price;
  logic [31:0]        order_quantity;
  logic [47:0]        order_time;
  modport source (output valid, op, order_tag, order_is_buy, order_price,
                  order_quantity, order_time, input ready);
  modport sink   (input valid, op, order_tag, order_is_buy, order_price,
                  order_quantity, order_time, output ready);
endinterface

>>> sv/cau_res_if.sv
// Result channel.
interface cau_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               ok;
  logic [15:0]        fill_tag;
  logic               fill_is_buy;
  logic [36:0]        amount;
  logic signed [31:0] cross_price;
  logic               beyond_band;
  logic               last;
  modport source (output valid, kind, ok, fill_tag, fill_is_buy, amount,
                  cross_price, beyond_band, last, input ready);
  modport sink   (input valid, kind, ok, fill_tag, fill_is_buy, amount,
                  cross_price, beyond_band, last, output ready);
endinterface

>>> sv/cau_front.sv
// Front: accepts input beats, drops unused op codes, queues the rest.
`include "assert_macros.svh"
module cau_front (
  input  logic                 clk,
  input  logic                 rst,
  cau_item_if.sink             item_ch,
  output cau_pkg::queue_head_t head,
  input  logic                 pop
);
  import cau_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             take;
  item_t            in_item;

  assign in_item = '{op: item_ch.op, order_tag: item_ch.order_tag,
                     order_is_buy: item_ch.order_is_buy,
                     order_price: item_ch.order_price,
                     order_quantity: item_ch.order_quantity,
                     order_time: item_ch.order_time};

  assign item_ch.ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  // op code three is swallowed here: it causes no result
  assign push = item_ch.valid && item_ch.ready &&
                (in_item.op == OP_ADD || in_item.op == OP_REMOVE ||
                 in_item.op == OP_UNCROSS);
  assign take = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  `CAU_ASSERT_NXT(a_count_track, push && !take, count == $past(count) + 1'b1,
                  "queue count lost a push")
  `CAU_ASSERT_IMP(a_no_overflow, count == (PTR_W+1)'(QUEUE_DEPTH), !push,
                  "push into full queue")
  `CAU_ASSERT_NXT(a_pop_track, take && !push, count == $past(count) - 1'b1,
                  "queue count lost a pop")

endmodule

>>> sv/cau_back.sv
// Back: order book, add/remove, uncross search and fill sequencing.
`include "assert_macros.svh"
module cau_back (
  input  logic                        clk,
  input  logic                        rst,
  input  cau_pkg::queue_head_t        head,
  output logic                        pop,
  input  logic                        cfg_we,
  input  logic [cau_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  cau_res_if.source                   res_ch
);
  import cau_pkg::*;

  function automatic logic [32:0] absdiff(logic signed [31:0] a,
                                          logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  // book
  logic [BOOK_DEPTH-1:0] valid_v;
  logic [15:0]        b_tag   [BOOK_DEPTH];
  logic               b_buy   [BOOK_DEPTH];
  logic signed [31:0] b_price [BOOK_DEPTH];
  logic [31:0]        b_qty   [BOOK_DEPTH];
  logic [47:0]        b_time  [BOOK_DEPTH];
  logic [31:0]        b_arr   [BOOK_DEPTH];
  logic [31:0]        arrival_counter;

  logic signed [31:0] ref_price;
  logic [15:0]        band_num;
  logic [15:0]        band_den;

  state_t state, state_next;
  item_t  cur;
  logic [IDX_W-1:0] scan, cidx;

  // search and ranking registers
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [31:0]        best_age;
  logic signed [31:0] best_price;
  logic [47:0]        best_time;
  logic [31:0]        best_qty;
  logic [15:0]        best_tag;

  logic               crossed;
  logic signed [31:0] bp;
  logic [VOL_W-1:0]   bv, bimb, dem, sup, left;
  logic signed [31:0] cand_price;
  logic               side_buy;
  logic [BOOK_DEPTH-1:0] done_mask;
  logic [48:0]        prod_l;
  logic [48:0]        prod_r;

  res_t res;
  logic res_valid;

  // read port
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_valid;
  logic signed [31:0] rd_price;
  logic [31:0]        rd_qty;
  logic [31:0]        rd_age;
  logic [IDX_W-1:0]   free_idx;
  logic               full;

  assign rd_addr  = (state == S_UX_CAND) ? cidx : scan;
  assign rd_valid = valid_v[rd_addr];
  assign rd_price = b_price[rd_addr];
  assign rd_qty   = b_qty[rd_addr];
  assign rd_age   = arrival_counter - b_arr[rd_addr];
  assign full     = &valid_v;

  always_comb begin
    free_idx = '0;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
      if (!valid_v[i]) free_idx = IDX_W'(i);
    end
  end

  // candidate evaluation
  logic [VOL_W-1:0] ex, imb;
  logic [32:0]      dist_c, dist_b;
  logic             ref_pos, better;
  assign ex      = (dem < sup) ? dem : sup;
  assign imb     = (dem > sup) ? dem - sup : sup - dem;
  assign ref_pos = (ref_price > 0);
  assign dist_c  = absdiff(cand_price, ref_price);
  assign dist_b  = absdiff(bp, ref_price);

  always_comb begin
    if (!crossed) better = 1'b1;
    else if (ex != bv) better = ex > bv;
    else if (imb != bimb) better = imb < bimb;
    else if (ref_pos && dist_c != dist_b) better = dist_c < dist_b;
    else better = cand_price > bp;
  end

  // fill ranking
  logic elig, rank_first, rm_hit;
  logic [31:0] take;
  always_comb begin
    elig = rd_valid && rd_qty != '0 && b_buy[rd_addr] == side_buy &&
           !done_mask[rd_addr] && (side_buy ? rd_price >= bp : rd_price <= bp);
    if (!found) rank_first = 1'b1;
    else if (rd_price != best_price)
      rank_first = side_buy ? rd_price > best_price : rd_price < best_price;
    else if (b_time[rd_addr] != best_time) rank_first = b_time[rd_addr] < best_time;
    else rank_first = rd_age > best_age;
    rm_hit = rd_valid && b_tag[rd_addr] == cur.order_tag &&
             (!found || rd_age > best_age);
  end
  assign take = (VOL_W'(best_qty) < left) ? best_qty : left[31:0];

  // emit
  logic out_free, emit_req, fire;
  res_t emit_res;
  assign out_free = !res_valid || res_ch.ready;
  assign fire     = emit_req && out_free;

  always_comb begin
    emit_req = 1'b0;
    emit_res = '0;
    case (state)
      S_ADD: begin
        emit_req = 1'b1;
        emit_res.kind = KIND_ADD_ACK;
        emit_res.ok = !full;
        emit_res.last = 1'b1;
      end
      S_RM_ACK: begin
        emit_req = 1'b1;
        emit_res.kind = KIND_RM_ACK;
        emit_res.ok = found;
        emit_res.last = 1'b1;
      end
      S_UX_DONE: begin
        emit_req = !crossed;
        emit_res.kind = KIND_SUMMARY;
        emit_res.last = 1'b1;
      end
      S_SUMMARY: begin
        emit_req = 1'b1;
        emit_res.kind = KIND_SUMMARY;
        emit_res.ok = 1'b1;
        emit_res.amount = bv[36:0];
        emit_res.cross_price = bp;
        emit_res.beyond_band = ref_pos && (prod_l > prod_r);
      end
      S_FILL_EMIT: begin
        emit_req = 1'b1;
        emit_res.kind = KIND_FILL;
        emit_res.fill_tag = best_tag;
        emit_res.fill_is_buy = side_buy;
        emit_res.amount = 37'(take);
        emit_res.cross_price = bp;
        emit_res.last = !side_buy && (VOL_W'(take) == left);
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign pop = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (head.valid) begin
          case (head.item.op)
            OP_ADD:     state_next = S_ADD;
            OP_REMOVE:  state_next = S_RM_SCAN;
            OP_UNCROSS: state_next = S_UX_CAND;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ADD:     if (fire) state_next = S_IDLE;
      S_RM_SCAN: if (scan == LAST_IDX) state_next = S_RM_ACK;
      S_RM_ACK:  if (fire) state_next = S_IDLE;
      S_UX_CAND: begin
        if (rd_valid && rd_price > 0) state_next = S_UX_SUM;
        else if (cidx == LAST_IDX) state_next = S_UX_DONE;
      end
      S_UX_SUM:  if (scan == LAST_IDX) state_next = S_UX_EVAL;
      S_UX_EVAL: state_next = (cidx == LAST_IDX) ? S_UX_DONE : S_UX_CAND;
      S_UX_DONE: begin
        if (crossed) state_next = S_BAND;
        else if (fire) state_next = S_IDLE;
      end
      S_BAND:    state_next = S_SUMMARY;
      S_SUMMARY: if (fire) state_next = S_FILL_SCAN;
      S_FILL_SCAN: if (scan == LAST_IDX) state_next = S_FILL_DEC;
      S_FILL_DEC: begin
        if (found) state_next = S_FILL_EMIT;
        else state_next = side_buy ? S_FILL_SCAN : S_IDLE;
      end
      S_FILL_EMIT: begin
        if (fire) begin
          if (VOL_W'(take) == left) state_next = side_buy ? S_FILL_SCAN : S_IDLE;
          else state_next = S_FILL_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      valid_v         <= '0;
      arrival_counter <= '0;
      ref_price       <= '0;
      band_num        <= 16'd1;
      band_den        <= 16'd10;
      res_valid       <= 1'b0;
      crossed         <= 1'b0;
      found           <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_REF: ref_price <= cfg_data;
          CFG_NUM: band_num  <= cfg_data[15:0];
          CFG_DEN: band_den  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (fire) res_valid <= 1'b1;
      else if (res_ch.ready) res_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          found   <= 1'b0;
          crossed <= 1'b0;
        end
        S_ADD: begin
          if (fire && !full) begin
            valid_v[free_idx] <= 1'b1;
            arrival_counter   <= arrival_counter + 1'b1;
          end
        end
        S_RM_SCAN: begin
          if (rm_hit) found <= 1'b1;
        end
        S_RM_ACK: begin
          if (fire && found) valid_v[best_idx] <= 1'b0;
        end
        S_UX_EVAL: begin
          if (ex != '0 && better) begin
            crossed <= 1'b1;
            bp      <= cand_price;
            bv      <= ex;
            bimb    <= imb;
          end
        end
        S_FILL_SCAN: begin
          if (elig && rank_first) found <= 1'b1;
        end
        S_FILL_EMIT: begin
          if (fire) found <= 1'b0;
        end
        S_FILL_DEC: begin
          if (!found) found <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath without reset
  always_ff @(posedge clk) begin
    if (fire) res <= emit_res;
    case (state)
      S_IDLE: begin
        cur  <= head.item;
        scan <= '0;
        cidx <= '0;
      end
      S_ADD: begin
        if (fire && !full) begin
          b_tag[free_idx]   <= cur.order_tag;
          b_buy[free_idx]   <= cur.order_is_buy;
          b_price[free_idx] <= cur.order_price;
          b_qty[free_idx]   <= cur.order_quantity;
          b_time[free_idx]  <= cur.order_time;
          b_arr[free_idx]   <= arrival_counter;
        end
      end
      S_RM_SCAN: begin
        scan <= scan + 1'b1;
        if (rm_hit) begin
          best_idx <= rd_addr;
          best_age <= rd_age;
        end
      end
      S_UX_CAND: begin
        cand_price <= rd_price;
        dem        <= '0;
        sup        <= '0;
        scan       <= '0;
        if (!(rd_valid && rd_price > 0)) cidx <= cidx + 1'b1;
      end
      S_UX_SUM: begin
        scan <= scan + 1'b1;
        if (rd_valid && rd_qty != '0) begin
          if (b_buy[rd_addr] && rd_price >= cand_price) dem <= dem + VOL_W'(rd_qty);
          if (!b_buy[rd_addr] && rd_price <= cand_price) sup <= sup + VOL_W'(rd_qty);
        end
      end
      S_UX_EVAL: cidx <= cidx + 1'b1;
      S_BAND: begin
        prod_l    <= 49'(dist_b) * 49'(band_den);
        prod_r    <= 49'(ref_price[30:0]) * 49'(band_num);
        left      <= bv;
        side_buy  <= 1'b1;
        done_mask <= '0;
        scan      <= '0;
      end
      S_FILL_SCAN: begin
        scan <= scan + 1'b1;
        if (elig && rank_first) begin
          best_idx   <= rd_addr;
          best_price <= rd_price;
          best_time  <= b_time[rd_addr];
          best_age   <= rd_age;
          best_qty   <= rd_qty;
          best_tag   <= b_tag[rd_addr];
        end
      end
      S_FILL_DEC: begin
        scan <= '0;
        if (!found) begin
          side_buy <= 1'b0;
          left     <= bv;
        end
      end
      S_FILL_EMIT: begin
        if (fire) begin
          done_mask[best_idx] <= 1'b1;
          scan <= '0;
          if (VOL_W'(take) == left) begin
            side_buy <= 1'b0;
            left     <= bv;
          end else begin
            left <= left - VOL_W'(take);
          end
        end
      end
      default: ;
    endcase
  end

  assign res_ch.valid       = res_valid;
  assign res_ch.kind        = res.kind;
  assign res_ch.ok          = res.ok;
  assign res_ch.fill_tag    = res.fill_tag;
  assign res_ch.fill_is_buy = res.fill_is_buy;
  assign res_ch.amount      = res.amount;
  assign res_ch.cross_price = res.cross_price;
  assign res_ch.beyond_band = res.beyond_band;
  assign res_ch.last        = res.last;

  `CAU_ASSERT_NXT(a_arrival_only_add, state != S_ADD, $stable(arrival_counter),
                  "arrival counter moved outside an add")
  `CAU_ASSERT_NXT(a_left_held, state == S_FILL_SCAN, $stable(left),
                  "remaining volume changed during a rank scan")
  `CAU_ASSERT_IMP(a_summary_crossed, state == S_SUMMARY, crossed && bv != '0,
                  "summary without a cross")

endmodule

>>> sv/call_auction_uncross.sv
// Top level of the call auction uncrossing block.
//
//  channel   | dir | handshake     | carries
//  item_ch   | in  | valid/ready   | op, order fields
//  res_ch    | out | valid/ready   | acks, cross summary, fills
//  cfg       | in  | cfg_we        | reference price, band numerator/denominator
//
// Add writes one free slot; remove scans the book one slot per cycle.
// Uncross runs a candidate search, summing demand and supply over the whole book
// for each priced entry, then a rank scan of the book for each fill; the single
// book read port forces these scans. One item is processed at a time; a two-beat
// queue accepts input while the back end works. Reset is synchronous and empties
// the book at once. A stalled result holds the back end in place.
module call_auction_uncross (
  input  logic                          clk,
  input  logic                          rst,
  cau_item_if.sink                      item_ch,
  cau_res_if.source                     res_ch,
  input  logic                          cfg_we,
  input  logic [cau_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import cau_pkg::*;

  queue_head_t head;
  logic        pop;

  cau_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item_ch (item_ch),
    .head    (head),
    .pop     (pop)
  );

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_ch    (res_ch)
  );

endmodule

>>> test/cau_tb_if.sv
`timescale 1ns / 100ps
// Testbench helper package: random op code choice.
package cau_tb_util;
  import cau_pkg::*;
  function automatic logic [1:0] rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_ADD;
    if (r < 75) return OP_REMOVE;
    return OP_UNCROSS;
  endfunction
endpackage

>>> test/call_auction_uncross_tb.sv
`timescale 1ns / 100ps
// Testbench of the call auction uncrossing block with a book predictor and scoreboard.
module call_auction_uncross_tb;
  import cau_pkg::*;

  // op code with no meaning; the block drops it
  localparam logic [1:0] OP_SPARE = 2'd3;

  class auction_scoreboard;
    bit               valid_e [BOOK_DEPTH];
    logic [15:0]      tag_e   [BOOK_DEPTH];
    bit               buy_e   [BOOK_DEPTH];
    longint           price_e [BOOK_DEPTH];
    longint unsigned  qty_e   [BOOK_DEPTH];
    longint unsigned  time_e  [BOOK_DEPTH];
    bit [31:0]        arr_e   [BOOK_DEPTH];
    bit [31:0]        arr_cnt;
    longint           ref_px;
    longint unsigned  num, den;
    res_t             pending[$];
    int               errors;

    function void clear();
      foreach (valid_e[i]) valid_e[i] = 0;
      arr_cnt = 0; ref_px = 0; num = 1; den = 10; errors = 0;
      pending.delete();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      if (idx == CFG_REF) ref_px = longint'($signed(d));
      else if (idx == CFG_NUM) num = d[15:0];
      else if (idx == CFG_DEN) den = d[15:0];
    endfunction

    function bit [31:0] age(int i);
      return arr_cnt - arr_e[i];
    endfunction

    function bit ahead(int a, int b, bit buy);
      if (price_e[a] != price_e[b]) return buy ? price_e[a] > price_e[b] : price_e[a] < price_e[b];
      if (time_e[a] != time_e[b]) return time_e[a] < time_e[b];
      return age(a) > age(b);
    endfunction

    function longint unsigned adiff(longint a, longint b);
      return a >= b ? a - b : b - a;
    endfunction

    function void push(logic [1:0] k, bit ok, logic [15:0] tg, bit by,
                       longint unsigned amt, longint px, bit bb, bit lst);
      res_t r;
      r.kind = k; r.ok = ok; r.fill_tag = tg; r.fill_is_buy = by;
      r.amount = amt[36:0]; r.cross_price = px[31:0]; r.beyond_band = bb; r.last = lst;
      pending = {pending, r};
    endfunction

    function void note_item(item_t it);
      int hit, n, m;
      int lst[BOOK_DEPTH];
      longint bp, p;
      longint unsigned bv, bimb, dm, sp, ex, imb, left, take;
      bit crossed, better, bb;
      res_t sum;
      if (it.op == OP_ADD) begin
        for (int i = 0; i < BOOK_DEPTH; i++)
          if (!valid_e[i]) begin
            valid_e[i] = 1; tag_e[i] = it.order_tag; buy_e[i] = it.order_is_buy;
            price_e[i] = longint'(it.order_price); qty_e[i] = it.order_quantity;
            time_e[i] = it.order_time; arr_e[i] = arr_cnt; arr_cnt++;
            push(KIND_ADD_ACK, 1, 0, 0, 0, 0, 0, 1);
            return;
          end
        push(KIND_ADD_ACK, 0, 0, 0, 0, 0, 0, 1);
      end else if (it.op == OP_REMOVE) begin
        hit = -1;
        for (int i = 0; i < BOOK_DEPTH; i++)
          if (valid_e[i] && tag_e[i] == it.order_tag && (hit < 0 || age(i) > age(hit)))
            hit = i;
        if (hit >= 0) valid_e[hit] = 0;
        push(KIND_RM_ACK, hit >= 0, 0, 0, 0, 0, 0, 1);
      end else if (it.op == OP_UNCROSS) begin
        crossed = 0; bp = 0; bv = 0; bimb = 0;
        for (int c = 0; c < BOOK_DEPTH; c++) begin
          if (!valid_e[c] || price_e[c] <= 0) continue;
          p = price_e[c]; dm = 0; sp = 0;
          for (int i = 0; i < BOOK_DEPTH; i++) begin
            if (!valid_e[i] || qty_e[i] == 0) continue;
            if (buy_e[i]) begin if (price_e[i] >= p) dm += qty_e[i]; end
            else if (price_e[i] <= p) sp += qty_e[i];
          end
          ex = dm < sp ? dm : sp;
          if (ex == 0) continue;
          imb = dm > sp ? dm - sp : sp - dm;
          if (!crossed) better = 1;
          else if (ex != bv) better = ex > bv;
          else if (imb != bimb) better = imb < bimb;
          else if (ref_px > 0 && adiff(p, ref_px) != adiff(bp, ref_px))
            better = adiff(p, ref_px) < adiff(bp, ref_px);
          else better = p > bp;
          if (better) begin crossed = 1; bp = p; bv = ex; bimb = imb; end
        end
        if (!crossed) begin
          push(KIND_SUMMARY, 0, 0, 0, 0, 0, 0, 1);
          return;
        end
        bb = 0;
        if (ref_px > 0) bb = adiff(bp, ref_px) * den > longint'(ref_px) * num;
        push(KIND_SUMMARY, 1, 0, 0, bv, bp, bb, 0);
        for (int s = 0; s < 2; s++) begin
          n = 0;
          for (int i = 0; i < BOOK_DEPTH; i++) begin
            if (!valid_e[i] || qty_e[i] == 0 || buy_e[i] != (s == 0)) continue;
            if ((s == 0) ? price_e[i] < bp : price_e[i] > bp) continue;
            m = n++;
            while (m > 0 && ahead(i, lst[m-1], s == 0)) begin lst[m] = lst[m-1]; m--; end
            lst[m] = i;
          end
          left = bv;
          for (int k = 0; k < n && left > 0; k++) begin
            take = qty_e[lst[k]] < left ? qty_e[lst[k]] : left;
            push(KIND_FILL, 0, tag_e[lst[k]], s == 0, take, bp, 0, 0);
            left -= take;
          end
        end
        sum = pending[$];
        sum.last = 1;
        pending[$] = sum;
      end
    endfunction

    function void check_result(res_t got);
      res_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      w = pending.pop_front();
      if (got !== w) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", w, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_REF;
  logic [31:0] cfg_data = 0;
  cau_item_if item_ch();
  cau_res_if  res_ch();
  auction_scoreboard book;
  bit stall_hold = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  call_auction_uncross DUT (.clk(clk), .rst(rst), .item_ch(item_ch.sink),
                            .res_ch(res_ch.source), .cfg_we(cfg_we),
                            .cfg_index(cfg_index), .cfg_data(cfg_data));

  initial begin
    item_ch.valid = 0; item_ch.op = OP_ADD; item_ch.order_tag = 0;
    item_ch.order_is_buy = 0; item_ch.order_price = 0;
    item_ch.order_quantity = 0; item_ch.order_time = 0;
    res_ch.ready = 0;
  end

  // receiver: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (rst || stall_hold) res_ch.ready <= 0;
    else res_ch.ready <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk)
    if (!rst && res_ch.valid && res_ch.ready) begin
      res_t r;
      r.kind = res_ch.kind; r.ok = res_ch.ok; r.fill_tag = res_ch.fill_tag;
      r.fill_is_buy = res_ch.fill_is_buy; r.amount = res_ch.amount;
      r.cross_price = res_ch.cross_price; r.beyond_band = res_ch.beyond_band;
      r.last = res_ch.last;
      book.check_result(r);
    end

  int burst_left = 0;

  task automatic send_item(item_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item_ch.valid <= 1; item_ch.op <= it.op; item_ch.order_tag <= it.order_tag;
    item_ch.order_is_buy <= it.order_is_buy; item_ch.order_price <= it.order_price;
    item_ch.order_quantity <= it.order_quantity; item_ch.order_time <= it.order_time;
    do @(posedge clk); while (!item_ch.ready);
    book.note_item(it);
    @(negedge clk);
    if (burst_left == 0) item_ch.valid <= 0;
  endtask

  task automatic drain();
    // a burst still open keeps valid high; drop it
    if (burst_left != 0) item_ch.valid <= 0;
    burst_left = 0;
    while (book.pending.size() != 0) @(negedge clk);
    repeat (BOOK_DEPTH * 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(negedge clk);
    cfg_we <= 0;
    book.set_reg(idx, d);
    @(negedge clk);
  endtask

  function automatic item_t order(logic [1:0] op, logic [15:0] tg, bit by,
                                  logic [31:0] px, logic [31:0] q, logic [47:0] t);
    item_t it;
    it.op = op; it.order_tag = tg; it.order_is_buy = by; it.order_price = px;
    it.order_quantity = q; it.order_time = t;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int r;
    it = order(cau_tb_util::rand_op(), 16'($urandom_range(0, 15)),
               1'($urandom_range(0, 1)),
               100 + $urandom_range(0, 20), $urandom_range(0, 50),
               48'({$urandom_range(0, 3), $urandom()}));
    r = $urandom_range(0, 19);
    if (r == 0) it.order_price = $urandom();
    if (r == 1) it.order_quantity = $urandom();
    if (r == 2) it.order_time = 48'({$urandom(), $urandom()});
    if (r == 3) it.order_tag = 16'($urandom());
    if (r == 4) it.order_price = -$urandom_range(0, 5);
    return it;
  endfunction

  task automatic random_phase(int cnt);
    for (int k = 0; k < cnt; k++) send_item(random_item());
  endtask

  initial begin
    book = new();
    book.clear();
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: empty book, extremes, full table, ties
    send_item(order(OP_UNCROSS, 0, 0, 0, 0, 0));
    send_item(order(OP_REMOVE, 16'hFFFF, 0, 0, 0, 0));
    send_item(order(OP_ADD, 16'hFFFF, 1, 32'h7FFFFFFF, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF));
    send_item(order(OP_ADD, 16'h0000, 0, 32'h80000000, 32'hFFFFFFFF, 0));
    send_item(order(OP_ADD, 1, 0, 100, 0, 5));
    send_item(order(OP_ADD, 2, 1, 100, 7, 5));
    send_item(order(OP_ADD, 2, 1, 100, 7, 5));
    send_item(order(OP_ADD, 3, 0, 90, 10, 3));
    send_item(order(OP_SPARE, 4, 0, 90, 10, 3));
    send_item(order(OP_UNCROSS, 0, 0, 0, 0, 0));
    send_item(order(OP_REMOVE, 2, 0, 0, 0, 0));
    send_item(order(OP_UNCROSS, 0, 0, 0, 0, 0));
    for (int k = 0; k < BOOK_DEPTH; k++)
      send_item(order(OP_ADD, 16'(16'h100 + k), k[0], 100 + k, 1000, 48'(k)));
    send_item(order(OP_UNCROSS, 0, 0, 0, 0, 0));
    drain();
    write_reg(CFG_REF, 110);
    write_reg(CFG_NUM, 0);
    write_reg(CFG_DEN, 65535);
    send_item(order(OP_UNCROSS, 0, 0, 0, 0, 0));
    for (int k = 0; k < BOOK_DEPTH + 2; k++)
      send_item(order(OP_REMOVE, 16'(16'h100 + k), 0, 0, 0, 0));
    send_item(order(OP_REMOVE, 16'hFFFF, 0, 0, 0, 0));
    send_item(order(OP_REMOVE, 16'h0000, 0, 0, 0, 0));
    send_item(order(OP_REMOVE, 1, 0, 0, 0, 0));
    send_item(order(OP_REMOVE, 3, 0, 0, 0, 0));
    drain();
    // hold the receiver off so the input queue backs up
    stall_hold = 1;
    fork
      begin
        repeat (400) @(negedge clk);
        stall_hold = 0;
      end
      random_phase(12);
    join
    random_phase(90);
    drain();
    write_reg(CFG_REF, 32'h7FFFFFFF);
    write_reg(CFG_NUM, 65535);
    write_reg(CFG_DEN, 1);
    random_phase(90);
    drain();
    write_reg(CFG_REF, 32'h80000000);
    write_reg(CFG_NUM, 3);
    write_reg(CFG_DEN, 50);
    random_phase(80);
    drain();
    write_reg(CFG_REF, 105);
    random_phase(80);
    drain();
    if (book.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/cau_pkg.sv
sv/cau_item_if.sv
sv/cau_res_if.sv
sv/cau_front.sv
sv/cau_back.sv
sv/call_auction_uncross.sv
test/cau_tb_if.sv
test/call_auction_uncross_tb.sv
